>>> rtl/sti_pkg.sv
// ---------------------------------------------------------------------------
// sti_pkg
// Shared types and codes for the sorted table insert/delete core: channel
// items, result status codes and the controller/datapath interface.
// ---------------------------------------------------------------------------
package sti_pkg;

  // operation codes carried in the mode field
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_DELETE = 1'b1;

  // result status codes
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  // input item
  typedef struct packed {
    logic               mode;
    logic signed [15:0] value;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [1:0] status;
    logic [5:0] position;
    logic [6:0] count_after;
  } out_item_t;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_CHK,
    S_INS_CMP,
    S_DEL_CHK,
    S_DEL_CMP,
    S_SHF_CHK,
    S_SHF_WR,
    S_FIN_DONE,
    S_FIN_FULL,
    S_FIN_NF
  } state_e;

  // table read address relative to the walking index
  typedef enum logic [1:0] {
    RA_BELOW,
    RA_AT,
    RA_ABOVE
  } rd_sel_e;

  // table write operations
  typedef enum logic [1:0] {
    WR_NONE,
    WR_MOVE_UP,
    WR_VALUE,
    WR_MOVE_DOWN
  } wr_op_e;

  // controller to datapath
  typedef struct packed {
    logic       load_ins;
    logic       load_del;
    logic       rd_en;
    rd_sel_e    rd_sel;
    wr_op_e     wr_op;
    logic       idx_inc;
    logic       pos_cap;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       res_load;
    logic [1:0] res_status;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic idx_zero;
    logic idx_at_end;
    logic idx_last;
    logic rd_gt;
    logic rd_eq;
    logic out_busy;
  } dp_stat_t;

endpackage

>>> rtl/sti_datapath.sv
// ---------------------------------------------------------------------------
// sti_datapath
// Table memory, entry count, walking index and the result register. Does
// one read or one write of the table per cycle as the controller commands.
// ---------------------------------------------------------------------------
module sti_datapath #(
  parameter int CAPACITY = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic signed [15:0] value_i,
  input  sti_pkg::dp_cmd_t   cmd_i,
  output sti_pkg::dp_stat_t  stat_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sti_pkg::out_item_t out_item_o
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic signed [15:0] mem [CAPACITY];
  logic signed [15:0] val_q, rd_q;
  logic [CW-1:0]      idx_q, idx_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [CW-1:0]      pos_q;
  logic [CW-1:0]      rd_addr;
  logic [CW:0]        idx_next_w;
  logic               wr_en;
  logic signed [15:0] wr_data;
  logic               out_valid_q, out_valid_d;
  sti_pkg::out_item_t out_q;
  logic [31:0]        pos_ext, cnt_ext;

  // read address around the walking index
  always_comb begin
    case (cmd_i.rd_sel)
      sti_pkg::RA_BELOW: rd_addr = idx_q - CW'(1);
      sti_pkg::RA_AT:    rd_addr = idx_q;
      sti_pkg::RA_ABOVE: rd_addr = idx_q + CW'(1);
      default:           rd_addr = idx_q;
    endcase
  end

  assign wr_en   = (cmd_i.wr_op != sti_pkg::WR_NONE);
  assign wr_data = (cmd_i.wr_op == sti_pkg::WR_VALUE) ? val_q : rd_q;

  // table memory, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[idx_q[AW-1:0]] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem[rd_addr[AW-1:0]];
    end
  end

  // operand and captured position
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_ins || cmd_i.load_del) begin
      val_q <= value_i;
    end
    if (cmd_i.pos_cap) begin
      pos_q <= idx_q;
    end
  end

  // walking index and entry count
  always_comb begin
    idx_d = idx_q;
    if (cmd_i.load_ins) begin
      idx_d = cnt_q;
    end else if (cmd_i.load_del) begin
      idx_d = '0;
    end else if (cmd_i.wr_op == sti_pkg::WR_MOVE_UP) begin
      idx_d = idx_q - CW'(1);
    end else if (cmd_i.wr_op == sti_pkg::WR_MOVE_DOWN || cmd_i.idx_inc) begin
      idx_d = idx_q + CW'(1);
    end
    cnt_d = cnt_q;
    if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      cnt_q <= '0;
    end else begin
      idx_q <= idx_d;
      cnt_q <= cnt_d;
    end
  end

  // status back to the controller
  assign idx_next_w       = {1'b0, idx_q} + (CW+1)'(1);
  assign stat_o.full       = (cnt_q == CW'(CAPACITY));
  assign stat_o.idx_zero   = (idx_q == '0);
  assign stat_o.idx_at_end = (idx_q >= cnt_q);
  assign stat_o.idx_last   = (idx_next_w >= {1'b0, cnt_q});
  assign stat_o.rd_gt      = (rd_q > val_q);
  assign stat_o.rd_eq      = (rd_q == val_q);
  assign stat_o.out_busy   = out_valid_q && out_stall_i;

  // result register
  assign pos_ext     = 32'(pos_q);
  assign cnt_ext     = 32'(cnt_q);
  assign out_valid_d = cmd_i.res_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      out_q.status      <= cmd_i.res_status;
      out_q.position    <= (cmd_i.res_status == sti_pkg::ST_DONE) ? pos_ext[5:0] : 6'd0;
      out_q.count_after <= cnt_ext[6:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // count stays within capacity
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // count moves by at most one per step
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |->
      ((cnt_q == $past(cnt_q) + CW'(1)) || (cnt_q == $past(cnt_q) - CW'(1))))
    else $error("entry count jumped");

  // walking index never passes the count
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= cnt_q)
    else $error("walking index beyond entry count");

  // table writes land inside the table
  a_wr_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (idx_q < CW'(CAPACITY)))
    else $error("table write out of range");

endmodule

>>> rtl/sti_ctrl.sv
// ---------------------------------------------------------------------------
// sti_ctrl
// Sequencer for insert and delete: walks the table one entry per check and
// compare/write state pair, issuing reads, moves and the final result load.
// ---------------------------------------------------------------------------
module sti_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              mode_i,
  output logic              in_stall_o,
  input  sti_pkg::dp_stat_t stat_i,
  output sti_pkg::dp_cmd_t  cmd_o
);

  sti_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sti_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.rd_sel     = sti_pkg::RA_AT;
    cmd_o.wr_op      = sti_pkg::WR_NONE;
    cmd_o.res_status = sti_pkg::ST_DONE;
    in_stall_o = (state_q != sti_pkg::S_IDLE);
    case (state_q)
      sti_pkg::S_IDLE: begin
        if (in_valid_i) begin
          if (mode_i == sti_pkg::MODE_INSERT) begin
            if (stat_i.full) begin
              state_d = sti_pkg::S_FIN_FULL;
            end else begin
              cmd_o.load_ins = 1'b1;
              state_d        = sti_pkg::S_INS_CHK;
            end
          end else begin
            cmd_o.load_del = 1'b1;
            state_d        = sti_pkg::S_DEL_CHK;
          end
        end
      end
      // insert: walk down from the top while the entry below is larger
      sti_pkg::S_INS_CHK: begin
        if (stat_i.idx_zero) begin
          cmd_o.wr_op   = sti_pkg::WR_VALUE;
          cmd_o.pos_cap = 1'b1;
          cmd_o.cnt_inc = 1'b1;
          state_d       = sti_pkg::S_FIN_DONE;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = sti_pkg::RA_BELOW;
          state_d      = sti_pkg::S_INS_CMP;
        end
      end
      sti_pkg::S_INS_CMP: begin
        if (stat_i.rd_gt) begin
          cmd_o.wr_op = sti_pkg::WR_MOVE_UP;
          state_d     = sti_pkg::S_INS_CHK;
        end else begin
          cmd_o.wr_op   = sti_pkg::WR_VALUE;
          cmd_o.pos_cap = 1'b1;
          cmd_o.cnt_inc = 1'b1;
          state_d       = sti_pkg::S_FIN_DONE;
        end
      end
      // delete: scan up for the first match
      sti_pkg::S_DEL_CHK: begin
        if (stat_i.idx_at_end) begin
          state_d = sti_pkg::S_FIN_NF;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = sti_pkg::RA_AT;
          state_d      = sti_pkg::S_DEL_CMP;
        end
      end
      sti_pkg::S_DEL_CMP: begin
        if (stat_i.rd_eq) begin
          cmd_o.pos_cap = 1'b1;
          state_d       = sti_pkg::S_SHF_CHK;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = sti_pkg::S_DEL_CHK;
        end
      end
      // close the gap, one entry at a time
      sti_pkg::S_SHF_CHK: begin
        if (stat_i.idx_last) begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = sti_pkg::S_FIN_DONE;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = sti_pkg::RA_ABOVE;
          state_d      = sti_pkg::S_SHF_WR;
        end
      end
      sti_pkg::S_SHF_WR: begin
        cmd_o.wr_op = sti_pkg::WR_MOVE_DOWN;
        state_d     = sti_pkg::S_SHF_CHK;
      end
      // hand the result over once the output register is free
      sti_pkg::S_FIN_DONE: begin
        if (!stat_i.out_busy) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = sti_pkg::ST_DONE;
          state_d          = sti_pkg::S_IDLE;
        end
      end
      sti_pkg::S_FIN_FULL: begin
        if (!stat_i.out_busy) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = sti_pkg::ST_FULL;
          state_d          = sti_pkg::S_IDLE;
        end
      end
      sti_pkg::S_FIN_NF: begin
        if (!stat_i.out_busy) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = sti_pkg::ST_NOT_FOUND;
          state_d          = sti_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = sti_pkg::S_IDLE;
      end
    endcase
  end

  // a result is only loaded while the output register can take it
  a_res_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.res_load |-> !stat_i.out_busy)
    else $error("result loaded over a held item");

  // the table is never read and written in the same cycle
  a_rd_wr_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_en |-> (cmd_o.wr_op == sti_pkg::WR_NONE))
    else $error("table read and write together");

  // an item is taken only from idle
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q != sti_pkg::S_IDLE))
    else $error("accepted item did not start an operation");

endmodule

>>> rtl/sorted_table_insert_delete_core.sv
// ---------------------------------------------------------------------------
// sorted_table_insert_delete_core
// Ascending table of signed 16-bit values with insert and delete.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_item_i) takes one operation:
//   mode insert places the value after any equal entries, mode delete removes
//   the lowest-index equal entry. Each operation gives exactly one item on
//   the output channel (out_valid_o / out_stall_i / out_item_o) with status,
//   position and the entry count afterwards.
//   One operation is worked at a time; the table sits in a single-port
//   memory and every entry moved or compared takes a read step and then a
//   compare/write step. An insert walks down from the top to its position,
//   a delete walks the whole table whether the value is found or absent,
//   and an insert into a full table goes straight to its result.
//   The input is taken again on the cycle after the result is loaded, even
//   if that result is still waiting to be taken. A stalled result holds in
//   the output register; a finished operation waits there until it is free.
//   Reset empties the table at once (the count goes to zero); no clearing
//   pass is needed since entries beyond the count are never read.
// ---------------------------------------------------------------------------
module sorted_table_insert_delete_core #(
  parameter int CAPACITY = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sti_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sti_pkg::out_item_t out_item_o
);

  sti_pkg::dp_cmd_t  cmd;
  sti_pkg::dp_stat_t stat;

  // sequencer
  sti_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .mode_i     (in_item_i.mode),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // table, count and result register
  sti_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (in_item_i.value),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

>>> test/sorted_table_insert_delete_core_test.sv
// ---------------------------------------------------------------------------
// sorted_table_insert_delete_core_test
// Self-checking bench for the sorted table core. A scoreboard keeps its own
// ascending copy of the table and entry count, predicts status, position
// and count for every accepted operation, and checks each result in order.
// Stimulus is a short directed run over edge values, duplicates and misses,
// then phases of fill, drain and mixed traffic with bursty input and a
// varying output stall, including one long output hold-off and one drain.
// ---------------------------------------------------------------------------
module sorted_table_insert_delete_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = 64;
  localparam int ITEM_TOTAL  = 1650;
  localparam int HOLD_CYCLES = 600;
  localparam int TAIL_CYCLES = 300;
  localparam int CYCLE_LIMIT = 1500000;

  typedef enum int {
    PH_FILL,
    PH_DRAIN,
    PH_MIX
  } phase_kind_e;

  // Shadow of the table: predicts one result item per accepted operation
  class sorted_table_sb;
    logic signed [15:0] entries [TABLE_DEPTH];
    int                 held;
    sti_pkg::out_item_t awaited [$];
    int                 fails;

    function new();
      held  = 0;
      fails = 0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // apply an accepted operation to the shadow table, queue its result
    function void note_op(sti_pkg::in_item_t op);
      sti_pkg::out_item_t res;
      logic signed [15:0] v;
      int                 slot;
      v   = op.value;
      res = '0;
      if (op.mode == sti_pkg::MODE_INSERT) begin
        if (held >= TABLE_DEPTH) begin
          res.status = sti_pkg::ST_FULL;
        end else begin
          // slot goes after every entry not greater than the value
          slot = 0;
          while (slot < held && entries[slot] <= v) slot++;
          for (int i = held; i > slot; i--) entries[i] = entries[i-1];
          entries[slot] = v;
          held++;
          res.status   = sti_pkg::ST_DONE;
          res.position = slot[5:0];
        end
      end else begin
        // lowest-index match
        slot = 0;
        while (slot < held && entries[slot] != v) slot++;
        if (slot >= held) begin
          res.status = sti_pkg::ST_NOT_FOUND;
        end else begin
          for (int i = slot; i + 1 < held; i++) entries[i] = entries[i+1];
          held--;
          res.status   = sti_pkg::ST_DONE;
          res.position = slot[5:0];
        end
      end
      res.count_after = held[6:0];
      awaited.push_back(res);
    endfunction

    // compare a taken result item with the oldest prediction
    function void check_result(sti_pkg::out_item_t got);
      sti_pkg::out_item_t want;
      if (awaited.size() == 0) begin
        $error("result with nothing expected: status %0d position %0d count %0d",
               got.status, got.position, got.count_after);
        fails++;
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status) begin
        $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
        fails++;
      end
      if (got.position !== want.position) begin
        $error("position mismatch: expected %0d, actual %0d",
               want.position, got.position);
        fails++;
      end
      if (got.count_after !== want.count_after) begin
        $error("count_after mismatch: expected %0d, actual %0d",
               want.count_after, got.count_after);
        fails++;
      end
    endfunction
  endclass

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  sti_pkg::in_item_t  in_item_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  sti_pkg::out_item_t out_item_o;

  sorted_table_sb sb;
  bit             hold_req    = 1'b0;
  int             burst_left  = 0;
  int             items_sent  = 0;
  int             cycle_count = 0;

  sorted_table_insert_delete_core #(
    .CAPACITY (TABLE_DEPTH)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // clock
  always #4 clk_i = ~clk_i;

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // output side: stall rate changes every so often, one long hold-off on request
  initial begin
    int stall_pct;
    int span;
    stall_pct = 0;
    span      = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        if (span == 0) begin
          case ($urandom_range(0, 4))
            0, 1:    stall_pct = 0;
            2:       stall_pct = 25;
            3:       stall_pct = 50;
            default: stall_pct = 85;
          endcase
          span = $urandom_range(20, 200);
        end else begin
          span--;
        end
        out_stall_i <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // take results
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_item_o);
  end

  function automatic sti_pkg::in_item_t mk_op(logic mode, logic [15:0] value);
    sti_pkg::in_item_t op;
    op.mode  = mode;
    op.value = value;
    return op;
  endfunction

  // values: small cluster for duplicates, edge values, or anything
  function automatic logic [15:0] pick_value();
    logic [15:0] v;
    int          r;
    r = $urandom_range(0, 9);
    if (r < 4) begin
      v = 16'($urandom_range(0, 8) - 4);
    end else if (r == 4) begin
      case ($urandom_range(0, 3))
        0:       v = 16'h8000;
        1:       v = 16'h7fff;
        2:       v = 16'hffff;
        default: v = 16'h0000;
      endcase
    end else begin
      v = 16'($urandom_range(0, 65535));
    end
    return v;
  endfunction

  // deletes mostly target a value that is held
  function automatic sti_pkg::in_item_t pick_op(phase_kind_e kind);
    sti_pkg::in_item_t op;
    int                ins_pct;
    case (kind)
      PH_FILL:  ins_pct = 90;
      PH_DRAIN: ins_pct = 10;
      default:  ins_pct = 50;
    endcase
    op.mode = ($urandom_range(0, 99) < ins_pct) ? sti_pkg::MODE_INSERT
                                                 : sti_pkg::MODE_DELETE;
    if (op.mode == sti_pkg::MODE_DELETE && sb.held > 0 && $urandom_range(0, 9) < 7)
      op.value = sb.entries[$urandom_range(0, sb.held - 1)];
    else
      op.value = pick_value();
    return op;
  endfunction

  // offer one item until taken
  task automatic send_op(sti_pkg::in_item_t op);
    in_valid_i <= 1'b1;
    in_item_i  <= op;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    sb.note_op(op);
    items_sent++;
  endtask

  // send within bursts, random gaps between them
  task automatic issue(sti_pkg::in_item_t op);
    int gap;
    send_op(op);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  // stop offering until every result has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // stimulus
  initial begin
    phase_kind_e kind;
    int          len;
    bit          paused;
    sb     = new();
    paused = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: miss on empty, edge values, duplicates, misses, bit patterns
    issue(mk_op(sti_pkg::MODE_DELETE, 16'h0000));
    issue(mk_op(sti_pkg::MODE_INSERT, 16'h0000));
    issue(mk_op(sti_pkg::MODE_INSERT, 16'h7fff));
    issue(mk_op(sti_pkg::MODE_INSERT, 16'h8000));
    issue(mk_op(sti_pkg::MODE_INSERT, 16'hffff));
    issue(mk_op(sti_pkg::MODE_INSERT, 16'h0005));
    issue(mk_op(sti_pkg::MODE_INSERT, 16'h0005));
    issue(mk_op(sti_pkg::MODE_INSERT, 16'h0005));
    issue(mk_op(sti_pkg::MODE_INSERT, 16'h0004));
    issue(mk_op(sti_pkg::MODE_INSERT, 16'h0006));
    issue(mk_op(sti_pkg::MODE_DELETE, 16'h0005));
    issue(mk_op(sti_pkg::MODE_DELETE, 16'h0005));
    issue(mk_op(sti_pkg::MODE_DELETE, 16'h0007));
    issue(mk_op(sti_pkg::MODE_DELETE, 16'h8000));
    issue(mk_op(sti_pkg::MODE_DELETE, 16'h7fff));
    issue(mk_op(sti_pkg::MODE_INSERT, 16'h5555));
    issue(mk_op(sti_pkg::MODE_INSERT, 16'haaaa));
    issue(mk_op(sti_pkg::MODE_DELETE, 16'h5555));
    issue(mk_op(sti_pkg::MODE_DELETE, 16'haaaa));
    issue(mk_op(sti_pkg::MODE_DELETE, 16'h0000));
    issue(mk_op(sti_pkg::MODE_DELETE, 16'h0000));
    issue(mk_op(sti_pkg::MODE_INSERT, 16'hffff));
    drain();

    // random phases; the first fills past capacity under a long output hold-off
    hold_req = 1'b1;
    kind     = PH_FILL;
    len      = TABLE_DEPTH + 8;
    while (items_sent < ITEM_TOTAL) begin
      for (int k = 0; k < len && items_sent < ITEM_TOTAL; k++) issue(pick_op(kind));
      if (!paused && items_sent >= ITEM_TOTAL / 2) begin
        drain();
        paused = 1'b1;
      end
      kind = phase_kind_e'($urandom_range(0, 2));
      len  = $urandom_range(20, 90);
    end

    // wind down
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/sti_pkg.sv
rtl/sti_datapath.sv
rtl/sti_ctrl.sv
rtl/sorted_table_insert_delete_core.sv
test/sorted_table_insert_delete_core_test.sv
